### design/lcdnw_pkg.sv
package lcdnw_pkg;

	// Field widths
	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int BIN_W    = 16;
	localparam int COUNT_W  = 4;
	localparam int BYTE_W   = 8;

	// BCD conversion layout: five digits, shift-add-3 over 16 bits
	localparam int BCD_DIGITS      = 5;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int STEPS_PER_STAGE = 4;
	localparam int NUM_STAGES      = BIN_W / STEPS_PER_STAGE;
	localparam int IDX_W           = 3;

	// Display constants
	localparam logic [ROW_W-1:0]   ROW_TOP       = 8'd1;
	localparam logic [ROW_W-1:0]   ROW_BOTTOM    = 8'd2;
	localparam logic [COL_W-1:0]   COL_FIRST     = 8'd1;
	localparam logic [COL_W-1:0]   NUM_COLS      = 8'd16;
	localparam logic [BYTE_W-1:0]  CMD_ROW1_BASE = 8'h7F;
	localparam logic [BYTE_W-1:0]  CMD_ROW2_BASE = 8'hBF;
	localparam logic [BYTE_W-1:0]  CMD_HOME      = 8'h80;
	localparam logic [BYTE_W-1:0]  ASCII_ZERO    = 8'd48;
	localparam logic [BYTE_W-1:0]  ERR_CHAR      = 8'h65;
	localparam logic [COUNT_W-1:0] MAX_DIGITS    = 4'd5;

	// Work item carried down the conversion pipeline
	typedef struct packed {
		logic [BYTE_W-1:0]  cmd;
		logic [COUNT_W-1:0] count;
		logic [BCD_W-1:0]   bcd;
		logic [BIN_W-1:0]   bin;
	} work_t;

	// Cursor address command; an out-of-range position homes
	function automatic logic [BYTE_W-1:0] cursor_cmd(logic [ROW_W-1:0] row,
			logic [COL_W-1:0] column);
		logic              col_ok;
		logic [BYTE_W-1:0] c;
		col_ok = (column >= COL_FIRST) && (column <= NUM_COLS);
		c = CMD_HOME;
		if (col_ok && row == ROW_TOP) begin
			c = CMD_ROW1_BASE + column;
		end else if (col_ok && row == ROW_BOTTOM) begin
			c = CMD_ROW2_BASE + column;
		end
		return c;
	endfunction

	// One shift-add-3 step: correct each BCD digit, then shift in the next bit
	function automatic work_t dabble_step(work_t w);
		work_t            r;
		logic [BCD_W-1:0] adj;
		r = w;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			adj[d*4 +: 4] = (w.bcd[d*4 +: 4] >= 4'd5) ? w.bcd[d*4 +: 4] + 4'd3
				: w.bcd[d*4 +: 4];
		end
		r.bcd = {adj[BCD_W-2:0], w.bin[BIN_W-1]};
		r.bin = {w.bin[BIN_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

### design/lcdnw_if.sv
// Request channel: one print request per transaction
interface lcdnw_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] row;
	logic [7:0] column;
	logic [15:0] value;
	logic [3:0] digit_count;

	modport source (output valid, row, column, value, digit_count, input ready);
	modport sink (input valid, row, column, value, digit_count, output ready);
endinterface

// Display bus channel: one LCD byte per transaction
interface lcdnw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, out_byte, is_data, last, input ready);
	modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

### design/lcdnw_stage.sv
module lcdnw_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lcdnw_pkg::work_t in_work,
	output logic            out_valid,
	input  logic            out_ready,
	output lcdnw_pkg::work_t out_work
);
	import lcdnw_pkg::*;

	work_t stepped;
	logic  valid_s;
	work_t work_s;

	// Four conversion steps per stage
	always_comb begin
		stepped = in_work;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			stepped = dabble_step(stepped);
		end
	end

	// Stage advances when empty or when the next stage takes its item
	assign in_ready = !valid_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s <= stepped;
		end
	end

	assign out_valid = valid_s;
	assign out_work  = work_s;

endmodule

### design/lcdnw_serializer.sv
module lcdnw_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lcdnw_pkg::work_t in_work,
	lcdnw_byte_if.source     disp
);
	import lcdnw_pkg::*;

	logic               valid_q;
	logic [BYTE_W-1:0]  cmd_q;
	logic [COUNT_W-1:0] count_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   last_idx_q;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   sel;
	logic [3:0]         nib;
	logic               is_last;
	logic               take;

	assign is_last  = (idx_q == last_idx_q);
	assign take     = disp.valid && disp.ready;
	assign in_ready = !valid_q || (take && is_last);

	// Index of the final byte: command only, command plus 'e', or command plus digits
	always_comb begin
		if (in_work.count == '0) begin
			last_idx = '0;
		end else if (in_work.count > MAX_DIGITS) begin
			last_idx = IDX_W'(1);
		end else begin
			last_idx = in_work.count[IDX_W-1:0];
		end
	end

	// Control: load a new request or step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q      <= in_work.cmd;
			count_q    <= in_work.count;
			bcd_q      <= in_work.bcd;
			last_idx_q <= last_idx;
		end
	end

	// Byte k of the digits maps to BCD digit (count - k), counting from the ones place
	assign sel = count_q[IDX_W-1:0] - idx_q;

	always_comb begin
		case (sel)
			3'd0:    nib = bcd_q[3:0];
			3'd1:    nib = bcd_q[7:4];
			3'd2:    nib = bcd_q[11:8];
			3'd3:    nib = bcd_q[15:12];
			3'd4:    nib = bcd_q[19:16];
			default: nib = 4'd0;
		endcase
	end

	// Output byte
	always_comb begin
		disp.valid = valid_q;
		disp.last  = is_last;
		if (idx_q == '0) begin
			disp.out_byte = cmd_q;
			disp.is_data  = 1'b0;
		end else begin
			disp.is_data = 1'b1;
			if (count_q > MAX_DIGITS) begin
				disp.out_byte = ERR_CHAR;
			end else begin
				disp.out_byte = ASCII_ZERO + {4'd0, nib};
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q <= last_idx_q)
		else $error("byte index past end of request");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !is_last) |=> (valid_q && idx_q == $past(idx_q) + 1'b1))
		else $error("request did not advance to its next byte");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (valid_q && idx_q == '0))
		else $error("new request did not start at its command byte");

	a_data_char: assert property (@(posedge clk) disable iff (!arst_n)
		(disp.valid && disp.is_data) |->
		((disp.out_byte >= ASCII_ZERO && disp.out_byte <= ASCII_ZERO + 8'd9)
		|| disp.out_byte == ERR_CHAR))
		else $error("data byte is neither a digit nor the error mark");

	a_cmd_first: assert property (@(posedge clk) disable iff (!arst_n)
		(disp.valid && !disp.is_data) |-> idx_q == '0)
		else $error("command byte outside first position");
`endif

endmodule

### design/lcd_decimal_number_writer.sv
// Decimal number writer for a two-line character LCD.
// req channel: one transaction per print request (row, column, value, digit_count).
// disp channel: one transaction per bus byte (out_byte, is_data, last). Each request
// gives a cursor command (is_data = 0), then digit_count ASCII digits with leading
// zeros, or the single character 'e' when digit_count exceeds five; last marks the
// final byte. A request yields 1 to 6 bytes.
// The command byte of a request reaches disp after the four binary-to-BCD stages of
// four shift-add-3 steps each, then the byte serializer. Requests may enter every
// cycle while the pipeline has room; the serializer sends one byte per cycle while
// disp is ready and loads the next request only as the last byte of the current
// one is taken.
// When disp stalls, the current byte holds and the stages fill behind it; req.ready
// drops once every stage holds a request. Nothing is lost or repeated.
// Reset clears the stage valid bits, the serializer valid bit and the byte index
// only; no request is in flight afterwards.
module lcd_decimal_number_writer (
	input logic          clk,
	input logic          arst_n,
	lcdnw_req_if.sink    req,
	lcdnw_byte_if.source disp
);
	import lcdnw_pkg::*;

	logic  stg_valid [NUM_STAGES+1];
	logic  stg_ready [NUM_STAGES+1];
	work_t stg_work  [NUM_STAGES+1];

	// Entry: cursor command, digit count and the raw value
	assign stg_valid[0] = req.valid;
	assign req.ready    = stg_ready[0];
	always_comb begin
		stg_work[0].cmd   = cursor_cmd(req.row, req.column);
		stg_work[0].count = req.digit_count;
		stg_work[0].bcd   = '0;
		stg_work[0].bin   = req.value;
	end

	// Binary to BCD pipeline
	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		lcdnw_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_valid[g]),
			.in_ready (stg_ready[g]),
			.in_work  (stg_work[g]),
			.out_valid(stg_valid[g+1]),
			.out_ready(stg_ready[g+1]),
			.out_work (stg_work[g+1])
		);
	end

	// Byte sequencing onto the display bus
	lcdnw_serializer u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(stg_valid[NUM_STAGES]),
		.in_ready(stg_ready[NUM_STAGES]),
		.in_work (stg_work[NUM_STAGES]),
		.disp    (disp)
	);

endmodule
